@@ hw/rtl/iba_pkg.sv @@
// ----------------------------------------------------------------------------
// iba_pkg: shared types and codes of the identifier bitmap allocator
// Operation and status codes, word geometry of the bitmap and the search
// token that travels along the row of bitmap cells.
// ----------------------------------------------------------------------------
package iba_pkg;

	localparam int ID_W       = 16;
	localparam int WORD_BITS  = 32;
	localparam int BIT_IDX_W  = 5;
	localparam int WORD_IDX_W = ID_W - BIT_IDX_W;
	localparam int DEF_NUM_IDS = 1024;
	localparam logic [ID_W-1:0] DEF_ID_BASE = 16'd100;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_RELEASE = 2'd1;
	localparam logic [1:0] MODE_CLEAR   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;

	localparam logic REG_ID_BASE = 1'b0;

	typedef struct packed {
		logic            active;
		logic            found;
		logic [ID_W-1:0] idx;
	} tok_t;

endpackage

@@ hw/rtl/iba_cell.sv @@
// ----------------------------------------------------------------------------
// iba_cell: one 32-entry word of the allocation bitmap
// Holds its word, takes the lowest free entry for a passing search token that
// has not found one yet, frees an entry on release and clears on request.
// ----------------------------------------------------------------------------
module iba_cell #(
	parameter int CELL_IDX   = 0,
	parameter int VALID_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iba_pkg::tok_t         tok_i,
	output iba_pkg::tok_t         tok_o,
	input  logic                  clr,
	input  logic                  rel_en,
	input  logic [iba_pkg::ID_W-1:0] rel_off
);
	import iba_pkg::*;

	localparam logic [WORD_BITS-1:0] VALID_MASK =
		(VALID_BITS >= WORD_BITS) ? {WORD_BITS{1'b1}} :
		WORD_BITS'((64'd1 << VALID_BITS) - 64'd1);
	localparam logic [WORD_IDX_W-1:0] MY_WORD = WORD_IDX_W'(CELL_IDX);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] free;
	logic [BIT_IDX_W-1:0] first_bit;
	logic                 any_free;
	logic                 take;
	logic                 rel_hit;
	tok_t                 tok_q;

	assign free     = ~word_q & VALID_MASK;
	assign any_free = |free;
	assign take     = tok_i.active & ~tok_i.found & any_free;
	assign rel_hit  = rel_en & (rel_off[ID_W-1:BIT_IDX_W] == MY_WORD);

	always_comb begin
		first_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free[i]) begin
				first_bit = BIT_IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else if (clr) begin
			word_q <= '0;
		end else if (take) begin
			word_q[first_bit] <= 1'b1;
		end else if (rel_hit) begin
			word_q[rel_off[BIT_IDX_W-1:0]] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.active <= 1'b0;
			tok_q.found  <= 1'b0;
			tok_q.idx    <= '0;
		end else begin
			tok_q.active <= tok_i.active;
			tok_q.found  <= tok_i.found | take;
			tok_q.idx    <= take ? {MY_WORD, first_bit} : tok_i.idx;
		end
	end

	assign tok_o = tok_q;

	a_found_active: assert property (@(posedge clk) disable iff (!arst_n)
		tok_q.found |-> tok_q.active)
		else $error("found token without active search");

	a_take_sets: assert property (@(posedge clk) disable iff (!arst_n)
		take && !clr |=> word_q[$past(first_bit)])
		else $error("taken entry not marked used");

	a_used_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(word_q & ~VALID_MASK) == '0)
		else $error("entry beyond the map marked used");

endmodule

@@ hw/rtl/id_bitmap_allocator.sv @@
// ----------------------------------------------------------------------------
// id_bitmap_allocator: first-free identifier allocator on a bitmap
// Allocate grants id_base plus the lowest free entry, release frees one
// identifier of the window, clear frees all. id_base is set over APB.
// ----------------------------------------------------------------------------
// Requests are taken with start while busy is low; each request gives exactly
// one result, shown for one cycle with done, and the receiver cannot stall.
// Release, clear and the unused mode give done in the cycle after they are
// taken and never raise busy, so a new request may follow at once. An
// allocate runs a search token along a row of ceil(NUM_IDS/32) bitmap cells,
// one cell per cycle, and keeps busy high until it leaves the last cell;
// the row's length sets the allocate rate. The map is all free after reset.
module id_bitmap_allocator #(
	parameter int NUM_IDS = iba_pkg::DEF_NUM_IDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [15:0] release_id,
	output logic        done,
	output logic [15:0] granted_id,
	output logic [1:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import iba_pkg::*;

	localparam int NUM_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
	localparam logic [ID_W:0] NUM_IDS_C = (ID_W + 1)'(NUM_IDS);

	typedef enum logic {IDLE, SCAN} state_t;

	state_t            state_q;
	logic [ID_W-1:0]   id_base_q;
	logic              done_q;
	logic [ID_W-1:0]   granted_q;
	logic [1:0]        status_q;
	logic              accept;
	logic [ID_W-1:0]   rel_off;
	logic              rel_ok;
	logic              rel_en;
	logic              clr;
	tok_t              tok [NUM_WORDS+1];
	logic [NUM_WORDS-1:0] active_vec;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ID_BASE) ? {{(32-ID_W){1'b0}}, id_base_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= DEF_ID_BASE;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_ID_BASE) begin
			id_base_q <= pwdata[ID_W-1:0];
		end
	end

	assign accept  = start & ~busy;
	assign rel_off = release_id - id_base_q;
	assign rel_ok  = {1'b0, rel_off} < NUM_IDS_C;
	assign rel_en  = accept & (mode == MODE_RELEASE) & rel_ok;
	assign clr     = accept & (mode == MODE_CLEAR);

	assign tok[0].active = accept & (mode == MODE_ALLOC);
	assign tok[0].found  = 1'b0;
	assign tok[0].idx    = '0;

	for (genvar k = 0; k < NUM_WORDS; k++) begin : g_cell
		localparam int VB = (k == NUM_WORDS - 1) ? (NUM_IDS - WORD_BITS * k) : WORD_BITS;
		iba_cell #(
			.CELL_IDX   (k),
			.VALID_BITS (VB)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_i   (tok[k]),
			.tok_o   (tok[k+1]),
			.clr     (clr),
			.rel_en  (rel_en),
			.rel_off (rel_off)
		);
		assign active_vec[k] = tok[k+1].active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			done_q    <= 1'b0;
			granted_q <= '0;
			status_q  <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (accept) begin
						granted_q <= '0;
						status_q  <= ST_OK;
						case (mode)
							MODE_ALLOC: begin
								state_q <= SCAN;
							end
							MODE_RELEASE: begin
								done_q   <= 1'b1;
								status_q <= rel_ok ? ST_OK : ST_INVALID;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				SCAN: begin
					if (tok[NUM_WORDS].active) begin
						state_q   <= IDLE;
						done_q    <= 1'b1;
						granted_q <= tok[NUM_WORDS].found ?
							id_base_q + tok[NUM_WORDS].idx : '0;
						status_q  <= tok[NUM_WORDS].found ? ST_OK : ST_EXHAUSTED;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q == SCAN);
	assign done       = done_q;
	assign granted_id = granted_q;
	assign status     = status_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(active_vec))
		else $error("more than one search in flight");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done || busy)
		else $error("request neither answered nor in search");

	a_exhausted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EXHAUSTED |-> granted_id == '0)
		else $error("exhausted result carries an identifier");

	a_token_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|active_vec) |-> busy)
		else $error("search in flight while idle");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the identifier bitmap allocator
// Sends allocate, release, clear and unused-mode requests under several
// id_base settings and sender pacings. A local copy of the bitmap predicts
// every result, and each done strobe is checked against it field by field.
// ----------------------------------------------------------------------------
import iba_pkg::*;

localparam int MAP_SIZE = DEF_NUM_IDS;
localparam logic [1:0] MODE_UNUSED = 2'd3;

typedef struct packed {
	logic [15:0] id;
	logic [1:0]  st;
} grant_t;

class grant_scoreboard;
	bit [MAP_SIZE-1:0] used_map;
	logic [15:0] id_base;
	grant_t owed_grants[$];
	int errors;
	int n_requests;
	int n_grants;
	int n_exhausted;
	int n_invalid;

	function new();
		used_map = '0;
		id_base = DEF_ID_BASE;
		errors = 0;
		n_requests = 0;
		n_grants = 0;
		n_exhausted = 0;
		n_invalid = 0;
	endfunction

	function void set_base(logic [15:0] v);
		id_base = v;
	endfunction

	function int pending();
		return owed_grants.size();
	endfunction

	function void note_request(logic [1:0] m, logic [15:0] rid);
		grant_t g;
		logic [15:0] offset;
		int i;
		g.id = '0;
		g.st = ST_OK;
		n_requests++;
		case (m)
			MODE_ALLOC: begin
				g.st = ST_EXHAUSTED;
				for (i = 0; i < MAP_SIZE; i++) begin
					if (!used_map[i]) begin
						used_map[i] = 1'b1;
						g.id = id_base + 16'(i);
						g.st = ST_OK;
						break;
					end
				end
				if (g.st == ST_OK)
					n_grants++;
				else
					n_exhausted++;
			end
			MODE_RELEASE: begin
				offset = rid - id_base;
				if (offset < MAP_SIZE) begin
					used_map[offset] = 1'b0;
				end else begin
					g.st = ST_INVALID;
					n_invalid++;
				end
			end
			MODE_CLEAR: used_map = '0;
			default: ;
		endcase
		owed_grants.push_back(g);
	endfunction

	function void check_result(logic [15:0] gid, logic [1:0] st);
		grant_t g;
		if (owed_grants.size() == 0) begin
			errors++;
			$display("%0t: result granted_id=%0d status=%0d with no request outstanding",
				$time, gid, st);
			return;
		end
		g = owed_grants.pop_front();
		if (gid !== g.id) begin
			errors++;
			$display("%0t: granted_id expected %0d actual %0d", $time, g.id, gid);
		end
		if (st !== g.st) begin
			errors++;
			$display("%0t: status expected %0d actual %0d", $time, g.st, st);
		end
	endfunction

	function int pick_used();
		int first;
		int k;
		first = $urandom_range(MAP_SIZE - 1, 0);
		for (k = 0; k < MAP_SIZE; k++)
			if (used_map[(first + k) % MAP_SIZE])
				return (first + k) % MAP_SIZE;
		return -1;
	endfunction
endclass

module tb_top;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  mode = MODE_ALLOC;
	logic [15:0] release_id = '0;
	logic        done;
	logic [15:0] granted_id;
	logic [1:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	grant_scoreboard sb = new();
	int idle_pct = 0;
	logic [15:0] last_base;

	id_bitmap_allocator #(.NUM_IDS(MAP_SIZE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.release_id(release_id),
		.done(done),
		.granted_id(granted_id),
		.status(status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(granted_id, status);
			if (start && !busy)
				sb.note_request(mode, release_id);
		end
	end

	task automatic send_request(input logic [1:0] m, input logic [15:0] rid);
		int gap;
		gap = 0;
		if ($urandom_range(99, 0) < idle_pct)
			gap = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 4) : $urandom_range(3, 1);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		release_id <= rid;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (busy || sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_id_base(input logic [15:0] v);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ID_BASE, 2'b00};
		pwdata <= {16'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_base(v);
		last_base = v;
		// read back through the same port
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== v) begin
			sb.errors++;
			$display("%0t: id_base read back expected %0d actual %0d", $time, v, prdata[15:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_release_id();
		int idx;
		int roll;
		logic [15:0] b;
		b = sb.id_base;
		roll = $urandom_range(99, 0);
		idx = sb.pick_used();
		if (roll < 60 && idx >= 0)
			return b + 16'(idx);
		if (roll < 75)
			return b + 16'($urandom_range(MAP_SIZE - 1, 0));
		if (roll < 85) begin
			case ($urandom_range(3, 0))
				0: return b - 16'd1;
				1: return b;
				2: return b + 16'(MAP_SIZE - 1);
				default: return b + 16'(MAP_SIZE);
			endcase
		end
		return 16'($urandom);
	endfunction

	task automatic random_request();
		int roll;
		// hold off now and then until every result is back
		if ($urandom_range(99, 0) < 2)
			drain();
		roll = $urandom_range(99, 0);
		if (roll < 50)
			send_request(MODE_ALLOC, 16'($urandom));
		else if (roll < 94)
			send_request(MODE_RELEASE, pick_release_id());
		else if (roll < 97)
			send_request(MODE_CLEAR, 16'($urandom));
		else
			send_request(MODE_UNUSED, 16'($urandom));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		last_base = DEF_ID_BASE;
		send_request(MODE_ALLOC, 16'hFFFF);
		send_request(MODE_ALLOC, 16'h0000);
		send_request(MODE_ALLOC, 16'h5555);
		send_request(MODE_RELEASE, DEF_ID_BASE + 16'd1);
		send_request(MODE_ALLOC, 16'hAAAA);
		send_request(MODE_RELEASE, DEF_ID_BASE - 16'd1);
		send_request(MODE_RELEASE, DEF_ID_BASE + 16'(MAP_SIZE));
		send_request(MODE_RELEASE, DEF_ID_BASE + 16'(MAP_SIZE - 1));
		send_request(MODE_RELEASE, 16'h0000);
		send_request(MODE_RELEASE, 16'hFFFF);
		send_request(MODE_UNUSED, 16'hFFFF);
		send_request(MODE_RELEASE, DEF_ID_BASE + 16'd2);
		send_request(MODE_CLEAR, 16'h0000);
		send_request(MODE_ALLOC, 16'h0000);
		send_request(MODE_UNUSED, 16'h0000);
		send_request(MODE_CLEAR, 16'hFFFF);

		set_id_base(16'd0);
		idle_pct = 19;
		repeat (170) random_request();

		set_id_base(16'd64511);
		idle_pct = 83;
		repeat (130) random_request();

		set_id_base(16'($urandom_range(64511, 0)));
		idle_pct = 0;
		// fill the whole map, run past exhaustion, then free and regrant the last entry
		send_request(MODE_CLEAR, 16'($urandom));
		repeat (MAP_SIZE + 3) send_request(MODE_ALLOC, 16'($urandom));
		send_request(MODE_RELEASE, sb.id_base + 16'(MAP_SIZE - 1));
		send_request(MODE_ALLOC, 16'($urandom));
		send_request(MODE_ALLOC, 16'($urandom));
		repeat (120) random_request();

		drain();
		repeat (40) @(posedge clk);
		$display("Run covered %0d requests: %0d grants, %0d exhausted, %0d invalid releases.",
			sb.n_requests, sb.n_grants, sb.n_exhausted, sb.n_invalid);
		$display("Bases 100, 0, 64511 and %0d; sender idling 19, 83 and 0 in a hundred.",
			last_base);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
